[src/bws_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, register codes and interface structs of the brightest window search.
// Used by every design module of the block and by the testbench; depends on nothing else.
package bws_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH         = 1024;
  localparam int MAX_WINDOW_HEIGHT = 1024;
  localparam int PIXEL_BITS        = 8;

  // Field and state widths.
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int SLOT_W  = $clog2(MAX_WINDOW_HEIGHT);
  localparam int FILL_W  = COL_W + 1;
  localparam int ROW_W   = 12;
  localparam int CFG_W   = 11;
  localparam int STEP_W  = 8;
  localparam int CSUM_W  = 18;
  localparam int WSUM_W  = 28;
  localparam int LINE_AW = SLOT_W + COL_W;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP          = 2'd3;

  // Register values after reset.
  localparam logic [CFG_W-1:0]  IMAGE_WIDTH_RST   = 11'd1024;
  localparam logic [CFG_W-1:0]  WINDOW_WIDTH_RST  = 11'd798;
  localparam logic [CFG_W-1:0]  WINDOW_HEIGHT_RST = 11'd660;
  localparam logic [STEP_W-1:0] STEP_RST          = 8'd2;

  // Grid remainder pipeline: GRID_BITS dividend bits per stage.
  localparam int GRID_W      = ROW_W;
  localparam int GRID_BITS   = 3;
  localparam int GRID_STAGES = GRID_W / GRID_BITS;

  // Item pipeline: stage 0 feeds the column update, stage 1 the window sum,
  // the last stage meets the grid result and updates the best window.
  localparam int PIPE_DEPTH = GRID_STAGES + 1;
  localparam int SUM_DELAY  = GRID_STAGES - 1;

  // Frame results that may be owed at once (in flight plus queued).
  localparam int PEND_W = 2;
  localparam logic [PEND_W-1:0] MAX_PENDING = 2'd2;

  // Column update request, taken in the cycle after the pixel is accepted.
  typedef struct packed {
    logic                  valid;
    logic [COL_W-1:0]      x;
    logic [PIXEL_BITS-1:0] pix;
    logic                  zero_col;
    logic                  sub_line;
  } col_req_t;

  // Horizontal running sum control.
  typedef struct packed {
    logic valid;
    logic x_zero;
    logic sub_back;
  } sum_req_t;

  // Window evaluation request.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             hit;
    logic [COL_W-1:0] left;
    logic [ROW_W-1:0] top;
  } eval_req_t;

  // One frame result.
  typedef struct packed {
    logic              found;
    logic [COL_W-1:0]  rect_x;
    logic [ROW_W-1:0]  rect_y;
    logic [WSUM_W-1:0] best_sum;
  } result_t;

endpackage

[src/bws_line_store.sv]
`timescale 1ns / 1ps
// Line delay store: one pixel per (delay slot, column), read before write at one address.
// Depends on bws_pkg.
module bws_line_store (
  input  logic                           clk,
  input  logic                           we,
  input  logic [bws_pkg::LINE_AW-1:0]    addr,
  input  logic [bws_pkg::PIXEL_BITS-1:0] wdata,
  output logic [bws_pkg::PIXEL_BITS-1:0] rdata
);
  import bws_pkg::*;

  logic [PIXEL_BITS-1:0] mem [2**LINE_AW];

  // The read returns the pixel that left this slot, the write stores the new one.
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule

[src/bws_column_sums.sv]
`timescale 1ns / 1ps
// Column running sums held in a memory with two read ports and one write port.
// Depends on bws_pkg.
module bws_column_sums (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bws_pkg::COL_W-1:0]   addr_cur,
  input  logic [bws_pkg::COL_W-1:0]   addr_back,
  input  bws_pkg::col_req_t           req,
  input  logic [bws_pkg::PIXEL_BITS-1:0] line_pix,
  output logic [bws_pkg::CSUM_W-1:0]  col_sum,
  output logic [bws_pkg::CSUM_W-1:0]  back_sum
);
  import bws_pkg::*;

  logic [CSUM_W-1:0] mem [MAX_WIDTH];
  logic [CSUM_W-1:0] rd_cur;
  logic [CSUM_W-1:0] rd_back;
  logic [CSUM_W-1:0] fwd_data;
  logic              fwd_cur;
  logic              fwd_back;
  logic [CSUM_W-1:0] old_cur;
  logic [CSUM_W-1:0] new_back;
  logic [CSUM_W-1:0] upd_sum;

  // A column not yet visited this frame reads as zero; a write landing on the
  // same edge as the read is forwarded.
  always_comb begin
    old_cur  = req.zero_col ? '0 : (fwd_cur ? fwd_data : rd_cur);
    new_back = fwd_back ? fwd_data : rd_back;
    upd_sum  = old_cur + CSUM_W'(req.pix) - (req.sub_line ? CSUM_W'(line_pix) : '0);
  end

  // Memory ports and the registered outputs.
  always_ff @(posedge clk) begin
    rd_cur  <= mem[addr_cur];
    rd_back <= mem[addr_back];
    if (req.valid) begin
      mem[req.x] <= upd_sum;
    end
    fwd_data <= upd_sum;
    col_sum  <= upd_sum;
    back_sum <= new_back;
  end

  // Note which read met the concurrent write.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_cur  <= 1'b0;
      fwd_back <= 1'b0;
    end else begin
      fwd_cur  <= req.valid && (req.x == addr_cur);
      fwd_back <= req.valid && (req.x == addr_back);
    end
  end

endmodule

[src/bws_grid_check.sv]
`timescale 1ns / 1ps
// Pipelined remainder of the window corner by the grid step, a few bits per stage.
// Depends on bws_pkg.
module bws_grid_check (
  input  logic                        clk,
  input  logic [bws_pkg::ROW_W-1:0]   top,
  input  logic [bws_pkg::COL_W-1:0]   left,
  input  logic [bws_pkg::STEP_W-1:0]  step,
  output logic                        top_ok,
  output logic                        left_ok
);
  import bws_pkg::*;

  logic [GRID_W-1:0] top_num  [GRID_STAGES+1];
  logic [GRID_W-1:0] left_num [GRID_STAGES+1];
  logic [STEP_W-1:0] top_rem  [GRID_STAGES+1];
  logic [STEP_W-1:0] left_rem [GRID_STAGES+1];
  logic [STEP_W-1:0] step_q   [GRID_STAGES+1];

  // Restoring remainder over GRID_BITS dividend bits, most significant first.
  function automatic logic [STEP_W-1:0] rem_digits(input logic [STEP_W-1:0] rem_in,
                                                   input logic [GRID_BITS-1:0] bits,
                                                   input logic [STEP_W-1:0] divisor);
    logic [STEP_W:0]   acc;
    logic [STEP_W-1:0] r;
    r = rem_in;
    for (int i = GRID_BITS - 1; i >= 0; i--) begin
      acc = {r, bits[i]};
      if (acc >= {1'b0, divisor}) begin
        acc = acc - {1'b0, divisor};
      end
      r = acc[STEP_W-1:0];
    end
    return r;
  endfunction

  // Stage 0 takes the dividends; each later stage consumes the top bits.
  always_ff @(posedge clk) begin
    top_num[0]  <= top;
    left_num[0] <= GRID_W'(left);
    top_rem[0]  <= '0;
    left_rem[0] <= '0;
    step_q[0]   <= step;
    for (int k = 0; k < GRID_STAGES; k++) begin
      top_num[k+1]  <= top_num[k] << GRID_BITS;
      left_num[k+1] <= left_num[k] << GRID_BITS;
      top_rem[k+1]  <= rem_digits(top_rem[k], top_num[k][GRID_W-1 -: GRID_BITS], step_q[k]);
      left_rem[k+1] <= rem_digits(left_rem[k], left_num[k][GRID_W-1 -: GRID_BITS], step_q[k]);
      step_q[k+1]   <= step_q[k];
    end
  end

  assign top_ok  = (top_rem[GRID_STAGES] == '0);
  assign left_ok = (left_rem[GRID_STAGES] == '0);

endmodule

[src/bws_window_eval.sv]
`timescale 1ns / 1ps
// Horizontal window sum, best window tracking and a two-entry result queue.
// Depends on bws_pkg.
module bws_window_eval (
  input  logic                        clk,
  input  logic                        rst,
  input  bws_pkg::sum_req_t           sum_req,
  input  logic [bws_pkg::CSUM_W-1:0]  col_sum,
  input  logic [bws_pkg::CSUM_W-1:0]  back_sum,
  input  bws_pkg::eval_req_t          eval_req,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bws_pkg::result_t            res
);
  import bws_pkg::*;

  logic [WSUM_W-1:0] win_sum;
  logic [WSUM_W-1:0] win_sum_next;
  logic [WSUM_W-1:0] sum_pipe [SUM_DELAY];
  logic [WSUM_W-1:0] sum_now;
  logic              any_seen;
  logic [WSUM_W-1:0] best_sum_q;
  logic [COL_W-1:0]  best_left;
  logic [ROW_W-1:0]  best_top;
  logic              take;
  logic              any_new;
  logic              push;
  logic              pop;
  result_t           res_d;
  result_t           q_head;
  result_t           q_tail;
  logic [1:0]        q_count;

  // Running sum over the last window_width column sums of the row.
  always_comb begin
    win_sum_next = (sum_req.x_zero ? '0 : win_sum) + WSUM_W'(col_sum)
                   - (sum_req.sub_back ? WSUM_W'(back_sum) : '0);
  end

  // The sum waits for the grid remainder to finish.
  always_ff @(posedge clk) begin
    if (sum_req.valid) begin
      win_sum <= win_sum_next;
    end
    sum_pipe[0] <= win_sum_next;
    for (int k = 1; k < SUM_DELAY; k++) begin
      sum_pipe[k] <= sum_pipe[k-1];
    end
  end

  assign sum_now = sum_pipe[SUM_DELAY-1];

  // Keep the first window with the strictly largest sum.
  always_comb begin
    take    = eval_req.valid && eval_req.hit && (!any_seen || (sum_now > best_sum_q));
    any_new = any_seen || take;
    push    = eval_req.valid && eval_req.last;
    pop     = res_valid && res_ready;
    res_d.found    = any_new;
    res_d.rect_x   = !any_new ? '0 : (take ? eval_req.left : best_left);
    res_d.rect_y   = !any_new ? '0 : (take ? eval_req.top : best_top);
    res_d.best_sum = !any_new ? '0 : (take ? sum_now : best_sum_q);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_sum_q <= sum_now;
      best_left  <= eval_req.left;
      best_top   <= eval_req.top;
    end
  end

  // The frame end starts a fresh search.
  always_ff @(posedge clk) begin
    if (rst) begin
      any_seen <= 1'b0;
    end else if (push) begin
      any_seen <= 1'b0;
    end else if (take) begin
      any_seen <= 1'b1;
    end
  end

  // Result queue: the head drives the port, the tail takes a second result.
  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (q_count == 2'd0) begin
          q_head <= res_d;
        end else begin
          q_tail <= res_d;
        end
      end
      2'b01: begin
        q_head <= q_tail;
      end
      2'b11: begin
        if (q_count == 2'd1) begin
          q_head <= res_d;
        end else begin
          q_head <= q_tail;
          q_tail <= res_d;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

  assign res_valid = (q_count != 2'd0);
  assign res       = q_head;

endmodule

[src/brightest_window_search.sv]
`timescale 1ns / 1ps
// Top level of the brightest window search: registers, raster position, item pipeline.
// Depends on bws_pkg, bws_line_store, bws_column_sums, bws_grid_check, bws_window_eval.
//
// Channel   Handshake                    Payload
// config    cfg_we                       cfg_index, cfg_data
// pixel     pixel_valid / pixel_ready    pixel, frame_end
// result    result_valid / result_ready  found, rect_x, rect_y, best_sum
//
// One pixel request is taken every clock while pixel_ready is high; the column sum memory is read
// at acceptance and written back in the next cycle, with the concurrent write forwarded.
// The frame result is queued once the frame_end pixel has passed the item pipeline,
// whose depth is that of the step remainder pipeline that meets the window sum.
// pixel_ready falls only while two frame results are owed and not yet taken.
// Reset is synchronous; the line store keeps its contents and column sums
// read as zero until first written in a frame, so no clearing pass follows reset.
module brightest_window_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bws_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                pixel_valid,
  output logic                                pixel_ready,
  input  logic [bws_pkg::PIXEL_BITS-1:0]      pixel,
  input  logic                                frame_end,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                found,
  output logic [bws_pkg::COL_W-1:0]           rect_x,
  output logic [bws_pkg::ROW_W-1:0]           rect_y,
  output logic [bws_pkg::WSUM_W-1:0]          best_sum
);
  import bws_pkg::*;

  typedef struct packed {
    logic             last;
    logic             cand;
    logic             x_zero;
    logic             sub_back;
    logic [COL_W-1:0] left;
    logic [ROW_W-1:0] top;
  } item_t;

  logic [CFG_W-1:0]    image_width;
  logic [CFG_W-1:0]    window_width;
  logic [CFG_W-1:0]    window_height;
  logic [STEP_W-1:0]   step;
  logic [CFG_W-1:0]    iw_eff;
  logic [CFG_W-1:0]    ww_eff;
  logic [CFG_W-1:0]    wh_eff;
  logic [STEP_W-1:0]   st_eff;

  logic [COL_W-1:0]    col_pos;
  logic [ROW_W-1:0]    row_pos;
  logic [SLOT_W-1:0]   slot;
  logic                row_ovf;
  logic [FILL_W-1:0]   fill;
  logic [PEND_W-1:0]   pending;

  logic                accept;
  logic [FILL_W-1:0]   x_inc;
  logic [ROW_W:0]      y_inc;
  logic [SLOT_W-1:0]   slot_eff;
  logic [SLOT_W:0]     slot_inc;
  logic                row_done;
  logic [ROW_W:0]      top_full;
  logic [FILL_W-1:0]   left_full;
  logic [FILL_W-1:0]   fill_next;
  logic [COL_W-1:0]    back_addr;
  item_t               item_d;
  col_req_t            col_req_d;
  col_req_t            col_req_q;

  item_t               pipe_item [PIPE_DEPTH];
  logic [PIPE_DEPTH-1:0] pipe_valid;

  logic [PIXEL_BITS-1:0] line_pix;
  logic [CSUM_W-1:0]   col_sum;
  logic [CSUM_W-1:0]   back_sum;
  logic                top_ok;
  logic                left_ok;
  sum_req_t            sum_req;
  eval_req_t           eval_req;
  result_t             res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMAGE_WIDTH_RST;
      window_width  <= WINDOW_WIDTH_RST;
      window_height <= WINDOW_HEIGHT_RST;
      step          <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_WINDOW_WIDTH:  window_width  <= cfg_data;
        REG_WINDOW_HEIGHT: window_height <= cfg_data;
        REG_STEP:          step          <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Zero acts as one; image width and window height are capped at the store sizes.
  always_comb begin
    iw_eff = (image_width == '0) ? CFG_W'(1) :
             (image_width > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : image_width;
    ww_eff = (window_width == '0) ? CFG_W'(1) : window_width;
    wh_eff = (window_height == '0) ? CFG_W'(1) :
             (window_height > CFG_W'(MAX_WINDOW_HEIGHT)) ? CFG_W'(MAX_WINDOW_HEIGHT) :
             window_height;
    st_eff = (step == '0) ? STEP_W'(1) : step;
  end

  // Raster position, window candidate and memory addresses for the request.
  always_comb begin
    accept    = pixel_valid && pixel_ready;
    x_inc     = {1'b0, col_pos} + FILL_W'(1);
    y_inc     = {1'b0, row_pos} + (ROW_W+1)'(1);
    slot_eff  = ({1'b0, slot} >= wh_eff) ? '0 : slot;
    slot_inc  = {1'b0, slot_eff} + (SLOT_W+1)'(1);
    row_done  = (x_inc >= iw_eff);
    top_full  = y_inc - (ROW_W+1)'(wh_eff);
    left_full = x_inc - ww_eff;
    fill_next = (x_inc > fill) ? x_inc : fill;
    back_addr = col_pos - ww_eff[COL_W-1:0];

    item_d.last     = frame_end;
    item_d.cand     = !row_ovf && (y_inc >= (ROW_W+1)'(wh_eff)) && (x_inc >= ww_eff);
    item_d.x_zero   = (col_pos == '0);
    item_d.sub_back = ({1'b0, col_pos} >= ww_eff);
    item_d.left     = left_full[COL_W-1:0];
    item_d.top      = top_full[ROW_W-1:0];

    col_req_d.valid    = accept;
    col_req_d.x        = col_pos;
    col_req_d.pix      = pixel;
    col_req_d.zero_col = ({1'b0, col_pos} >= fill);
    col_req_d.sub_line = row_ovf || (row_pos >= ROW_W'(wh_eff));
  end

  // Position state advances on every accepted pixel and clears at frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      slot    <= '0;
      row_ovf <= 1'b0;
      fill    <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col_pos <= '0;
        row_pos <= '0;
        slot    <= '0;
        row_ovf <= 1'b0;
        fill    <= '0;
      end else begin
        fill <= fill_next;
        if (row_done) begin
          col_pos <= '0;
          slot    <= (slot_inc >= (SLOT_W+1)'(wh_eff)) ? '0 : slot_inc[SLOT_W-1:0];
          if (y_inc[ROW_W]) begin
            row_ovf <= 1'b1;
          end else begin
            row_pos <= y_inc[ROW_W-1:0];
          end
        end else begin
          col_pos <= x_inc[COL_W-1:0];
          slot    <= slot_eff;
        end
      end
    end
  end

  // Frame results owed: accepted frame ends not yet taken at the result port.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({accept && frame_end, result_valid && result_ready})
        2'b10:   pending <= pending + PEND_W'(1);
        2'b01:   pending <= pending - PEND_W'(1);
        default: pending <= pending;
      endcase
    end
  end

  assign pixel_ready = (pending != MAX_PENDING);

  // Item pipeline; it never stalls.
  always_ff @(posedge clk) begin
    pipe_item[0] <= item_d;
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      pipe_item[k] <= pipe_item[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_req_q  <= '0;
      pipe_valid <= '0;
    end else begin
      col_req_q  <= col_req_d;
      pipe_valid <= {pipe_valid[PIPE_DEPTH-2:0], accept};
    end
  end

  bws_line_store u_line_store (
    .clk   (clk),
    .we    (accept),
    .addr  ({slot_eff, col_pos}),
    .wdata (pixel),
    .rdata (line_pix)
  );

  bws_column_sums u_column_sums (
    .clk       (clk),
    .rst       (rst),
    .addr_cur  (col_pos),
    .addr_back (back_addr),
    .req       (col_req_q),
    .line_pix  (line_pix),
    .col_sum   (col_sum),
    .back_sum  (back_sum)
  );

  bws_grid_check u_grid_check (
    .clk     (clk),
    .top     (item_d.top),
    .left    (item_d.left),
    .step    (st_eff),
    .top_ok  (top_ok),
    .left_ok (left_ok)
  );

  // Requests to the evaluator from the sum stage and the last stage.
  always_comb begin
    sum_req.valid    = pipe_valid[1];
    sum_req.x_zero   = pipe_item[1].x_zero;
    sum_req.sub_back = pipe_item[1].sub_back;

    eval_req.valid = pipe_valid[PIPE_DEPTH-1];
    eval_req.last  = pipe_item[PIPE_DEPTH-1].last;
    eval_req.hit   = pipe_item[PIPE_DEPTH-1].cand && top_ok && left_ok;
    eval_req.left  = pipe_item[PIPE_DEPTH-1].left;
    eval_req.top   = pipe_item[PIPE_DEPTH-1].top;
  end

  bws_window_eval u_window_eval (
    .clk       (clk),
    .rst       (rst),
    .sum_req   (sum_req),
    .col_sum   (col_sum),
    .back_sum  (back_sum),
    .eval_req  (eval_req),
    .res_valid (result_valid),
    .res_ready (result_ready),
    .res       (res)
  );

  assign found    = res.found;
  assign rect_x   = res.rect_x;
  assign rect_y   = res.rect_y;
  assign best_sum = res.best_sum;

endmodule

[src/bws_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the brightest window search, attached to the top level by bind.
// Depends only on the ports of brightest_window_search.
module bws_checker (
  input logic        clk,
  input logic        rst,
  input logic        pixel_valid,
  input logic        pixel_ready,
  input logic        frame_end,
  input logic        result_valid,
  input logic        result_ready,
  input logic        found,
  input logic [9:0]  rect_x,
  input logic [11:0] rect_y,
  input logic [27:0] best_sum
);

  logic [2:0] owed;

  // Frame results owed: frame ends accepted minus results taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= 3'd0;
    end else begin
      case ({pixel_valid && pixel_ready && frame_end, result_valid && result_ready})
        2'b10:   owed <= owed + 3'd1;
        2'b01:   owed <= owed - 3'd1;
        default: owed <= owed;
      endcase
    end
  end

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable({found, rect_x, rect_y, best_sum}))
    else $error("result changed or dropped while stalled");

  // No result without a frame end behind it.
  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> owed != 3'd0)
    else $error("result shown without an accepted frame end");

  // A frame without a window reports all zero fields.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> rect_x == 10'd0 && rect_y == 12'd0 && best_sum == 28'd0)
    else $error("empty result carries nonzero fields");

  // Pixels are refused only while two results are owed.
  a_ready_owed: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> owed == 3'd2)
    else $error("pixel_ready low with fewer than two results owed");

endmodule

bind brightest_window_search bws_checker u_bws_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel_valid),
  .pixel_ready  (pixel_ready),
  .frame_end    (frame_end),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .found        (found),
  .rect_x       (rect_x),
  .rect_y       (rect_y),
  .best_sum     (best_sum)
);

[tb/sv/brightest_window_search_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of brightest_window_search: directed frame table, random frames.
// Depends on bws_pkg and brightest_window_search; an internal window-sum tracker predicts.
module brightest_window_search_tb;
  import bws_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 20;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_PIXELS = 450;
  localparam int MIN_FRAMES    = 12;
  localparam int ROW_LIMIT     = 1 << ROW_W;
  localparam int BIG           = 1 << 20;
  localparam longint TIMEOUT_NS = 64'd4_000_000;

  // Pixel content of one frame.
  typedef enum {FILL_LEVELS, FILL_NOISE, FILL_DIM_PEAKS, FILL_BINARY} fill_e;

  // One frame of stimulus with the register values it runs under.
  typedef struct {
    bit          write_cfg;
    int unsigned iw, ww, wh, st;
    int unsigned length;
    fill_e       fill;
    int unsigned lvl0, split1, lvl1, split2, lvl2;
    bit          known;
    result_t     want;
  } frame_case_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_ready;
  logic [PIXEL_BITS-1:0] pixel = '0;
  logic                  frame_end = 1'b0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic                  found;
  logic [COL_W-1:0]      rect_x;
  logic [ROW_W-1:0]      rect_y;
  logic [WSUM_W-1:0]     best_sum;

  brightest_window_search u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .frame_end    (frame_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .found        (found),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .best_sum     (best_sum)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register copies and window-sum tracking state.
  logic [CFG_W-1:0]  img_w_reg, win_w_reg, win_h_reg;
  logic [STEP_W-1:0] step_reg;
  logic [7:0]        line_hist [int unsigned];
  logic [CSUM_W-1:0] col_acc [MAX_WIDTH];
  int unsigned       cur_col, cur_row, slot;
  logic [WSUM_W-1:0] run_sum, top_sum;
  logic [COL_W-1:0]  top_left;
  logic [ROW_W-1:0]  top_row;
  bit                any_fit, past_row_limit;

  // Frame results owed by the block, oldest first.
  result_t     owed_results [$];
  bit          use_typed;
  result_t     typed_result;

  int unsigned mismatch_count, results_checked, frames_found;
  int unsigned pixels_sent, frames_sent, settings_used;
  int unsigned feed_burst, drain_burst;
  bit          feed_tight, long_hold_req;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH result %0d %s: got %0d, expected %0d", results_checked, what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned effective(input int unsigned v, input int unsigned cap);
    if (v == 0) return 1;
    return (v > cap) ? cap : v;
  endfunction

  // Wait per request, with occasional stretches of back-to-back traffic.
  function automatic int unsigned draw_gap(inout int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  task automatic clear_frame_tracking();
    foreach (col_acc[i]) col_acc[i] = '0;
    cur_col = 0;
    cur_row = 0;
    slot = 0;
    run_sum = '0;
    top_sum = '0;
    top_left = '0;
    top_row = '0;
    any_fit = 1'b0;
    past_row_limit = 1'b0;
  endtask

  // Advance the column sums and the window sum by one accepted pixel.
  task automatic track_window_sums(input logic [7:0] pix, input bit last);
    int unsigned iw, ww, wh, st, idx, left, top;
    logic [CSUM_W-1:0] cs;
    result_t owed;
    iw = effective(img_w_reg, MAX_WIDTH);
    ww = effective(win_w_reg, 1 << CFG_W);
    wh = effective(win_h_reg, MAX_WINDOW_HEIGHT);
    st = effective(step_reg, 1 << STEP_W);

    // Vertical: add the new pixel, drop the one leaving the window.
    if (slot >= wh) slot = 0;
    idx = slot * MAX_WIDTH + cur_col;
    cs = col_acc[cur_col] + pix;
    if (past_row_limit || cur_row >= wh) cs = cs - line_hist[idx];
    col_acc[cur_col] = cs;
    line_hist[idx] = pix;

    // Horizontal running sum over the last ww column sums.
    if (cur_col == 0) run_sum = '0;
    run_sum = run_sum + col_acc[cur_col];
    if (cur_col >= ww) run_sum = run_sum - col_acc[cur_col - ww];

    // Keep the first grid window with the strictly largest sum.
    if (!past_row_limit && cur_row + 1 >= wh && cur_col + 1 >= ww) begin
      top = cur_row + 1 - wh;
      left = cur_col + 1 - ww;
      if (top % st == 0 && left % st == 0 && (!any_fit || run_sum > top_sum)) begin
        top_sum = run_sum;
        top_left = left[COL_W-1:0];
        top_row = top[ROW_W-1:0];
        any_fit = 1'b1;
      end
    end

    // Raster position; rows past the row counter range stop evaluation.
    if (cur_col + 1 >= iw) begin
      cur_col = 0;
      slot = (slot + 1 >= wh) ? 0 : slot + 1;
      if (cur_row + 1 >= ROW_LIMIT) past_row_limit = 1'b1;
      else cur_row++;
    end else begin
      cur_col++;
    end

    if (last) begin
      if (use_typed) begin
        owed = typed_result;
        use_typed = 1'b0;
      end else if (any_fit) begin
        owed = '{found: 1'b1, rect_x: top_left, rect_y: top_row, best_sum: top_sum};
      end else begin
        owed = '0;
      end
      owed_results.push_back(owed);
      if (owed.found) frames_found++;
      clear_frame_tracking();
    end
  endtask

  // Offer one pixel request and wait until it is taken.
  task automatic offer_pixel(input logic [7:0] value, input bit last);
    int unsigned gap;
    gap = feed_tight ? 0 : draw_gap(feed_burst);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= value;
    frame_end <= last;
    do @(posedge clk); while (pixel_ready !== 1'b1);
    track_window_sums(value, last);
    pixels_sent++;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:   img_w_reg = CFG_W'(value);
      REG_WINDOW_WIDTH:  win_w_reg = CFG_W'(value);
      REG_WINDOW_HEIGHT: win_h_reg = CFG_W'(value);
      default:           step_reg = STEP_W'(value);
    endcase
  endtask

  // Hold off input until every owed result has come, then load all registers.
  task automatic apply_settings(input int unsigned iw, ww, wh, st);
    pixel_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(REG_IMAGE_WIDTH, iw);
    write_register(REG_WINDOW_WIDTH, ww);
    write_register(REG_WINDOW_HEIGHT, wh);
    write_register(REG_STEP, st);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic frame_case_t mk_case(input bit write_cfg, input int unsigned iw, ww, wh,
                                          st, length, input fill_e fill,
                                          input int unsigned lvl0, split1, lvl1, split2, lvl2,
                                          input bit known, input bit want_found,
                                          input int unsigned want_x, want_y, want_sum);
    frame_case_t fc;
    fc.write_cfg = write_cfg;
    fc.iw = iw;
    fc.ww = ww;
    fc.wh = wh;
    fc.st = st;
    fc.length = length;
    fc.fill = fill;
    fc.lvl0 = lvl0;
    fc.split1 = split1;
    fc.lvl1 = lvl1;
    fc.split2 = split2;
    fc.lvl2 = lvl2;
    fc.known = known;
    fc.want = '{found: want_found, rect_x: COL_W'(want_x), rect_y: ROW_W'(want_y),
                best_sum: WSUM_W'(want_sum)};
    return fc;
  endfunction

  function automatic logic [7:0] frame_pixel(input frame_case_t fc, input int unsigned n);
    logic [7:0] v;
    case (fc.fill)
      FILL_LEVELS:    v = 8'((n < fc.split1) ? fc.lvl0 : (n < fc.split2) ? fc.lvl1 : fc.lvl2);
      FILL_NOISE:     v = 8'($urandom_range(0, 255));
      FILL_DIM_PEAKS: v = ($urandom_range(0, 15) == 0) ? 8'hFF : 8'($urandom_range(0, 15));
      default:        v = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endcase
    return v;
  endfunction

  task automatic send_frame(input frame_case_t fc);
    use_typed = fc.known;
    typed_result = fc.want;
    for (int unsigned n = 0; n < fc.length; n++)
      offer_pixel(frame_pixel(fc, n), n + 1 == fc.length);
    frames_sent++;
  endtask

  // One random register setting followed by a few frames, mostly with full window rows.
  task automatic run_random_phase();
    int unsigned iw, ww, wh, st, iwe, whe, len, s1;
    frame_case_t fc;
    iw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
    iwe = effective(iw, MAX_WIDTH);
    case ($urandom_range(0, 9))
      0:       ww = iwe + $urandom_range(1, 3);
      1:       ww = 0;
      default: ww = $urandom_range(1, iwe);
    endcase
    wh = $urandom_range(0, 5);
    whe = effective(wh, MAX_WINDOW_HEIGHT);
    st = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 4);
    apply_settings(iw, ww, wh, st);
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 3) != 0) begin
        len = (whe + $urandom_range(0, 3)) * iwe;
        if ($urandom_range(0, 2) == 0) len = len + $urandom_range(0, iwe - 1);
      end else begin
        len = $urandom_range(1, iwe * (whe + 2));
      end
      s1 = $urandom_range(0, len);
      fc = mk_case(1'b0, 0, 0, 0, 0, len, fill_e'($urandom_range(0, 3)),
                   $urandom_range(0, 255), s1, $urandom_range(0, 255),
                   $urandom_range(s1, len), $urandom_range(0, 255), 1'b0, 1'b0, 0, 0, 0);
      send_frame(fc);
    end
  endtask

  // Result side: random stalls, one long hold-off on request, field checks.
  initial begin
    int unsigned hold;
    result_t want;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = draw_gap(drain_burst);
      end
      if (hold > 0) begin
        result_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (result_valid !== 1'b1);
      if (owed_results.size() == 0) begin
        report_mismatch("result with nothing owed", 1, 0);
      end else begin
        want = owed_results.pop_front();
        if (found !== want.found) report_mismatch("found", found, want.found);
        if (rect_x !== want.rect_x) report_mismatch("rect_x", rect_x, want.rect_x);
        if (rect_y !== want.rect_y) report_mismatch("rect_y", rect_y, want.rect_y);
        if (best_sum !== want.best_sum) report_mismatch("best_sum", best_sum, want.best_sum);
      end
      results_checked++;
    end
  end

  // Stimulus: directed frame table, then random settings and frames.
  initial begin
    frame_case_t directed [$];
    int unsigned base_pixels, base_frames;
    bit squeezed;
    img_w_reg = IMAGE_WIDTH_RST;
    win_w_reg = WINDOW_WIDTH_RST;
    win_h_reg = WINDOW_HEIGHT_RST;
    step_reg = STEP_RST;
    clear_frame_tracking();

    // Reset settings, then zero registers acting as one.
    directed.push_back(mk_case(0, 0, 0, 0, 0, 5, FILL_LEVELS, 200, BIG, 0, BIG, 0,
                               1, 0, 0, 0, 0));
    directed.push_back(mk_case(1, 0, 0, 0, 0, 3, FILL_LEVELS, 7, 1, 9, BIG, 9,
                               1, 1, 0, 1, 9));
    // Oversize image width with the widest window.
    directed.push_back(mk_case(1, 2047, 1024, 1, 255, 1024, FILL_LEVELS, 255, BIG, 0, BIG, 0,
                               1, 1, 0, 0, 261120));
    // Window wider than the image, and a frame shorter than the window.
    directed.push_back(mk_case(1, 5, 6, 1, 1, 10, FILL_NOISE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk_case(1, 4, 2, 3, 1, 8, FILL_NOISE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk_case(1, 3, 3, 1500, 7, 9, FILL_NOISE, 0, 0, 0, 0, 0,
                               1, 0, 0, 0, 0));
    // Equal sums everywhere keep the first corner.
    directed.push_back(mk_case(1, 8, 2, 2, 2, 32, FILL_LEVELS, 100, BIG, 0, BIG, 0,
                               1, 1, 0, 0, 400));
    directed.push_back(mk_case(1, 1, 1, 1, 1, 1, FILL_LEVELS, 255, BIG, 0, BIG, 0,
                               1, 1, 0, 0, 255));
    // Partial last row, coarse steps and mixed content.
    directed.push_back(mk_case(1, 6, 2, 2, 1, 15, FILL_NOISE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_case(1, 10, 3, 2, 3, 60, FILL_NOISE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_case(1, 16, 2, 2, 255, 48, FILL_NOISE, 0, 0, 0, 0, 0,
                               0, 0, 0, 0, 0));
    directed.push_back(mk_case(1, 7, 0, 2, 0, 30, FILL_DIM_PEAKS, 0, 0, 0, 0, 0,
                               0, 0, 0, 0, 0));
    directed.push_back(mk_case(1, 9, 3, 3, 1, 45, FILL_LEVELS, 0, 20, 255, BIG, 255,
                               0, 0, 0, 0, 0));
    directed.push_back(mk_case(1, 12, 5, 4, 2, 100, FILL_BINARY, 0, 0, 0, 0, 0,
                               0, 0, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) begin
      if (directed[k].write_cfg)
        apply_settings(directed[k].iw, directed[k].ww, directed[k].wh, directed[k].st);
      send_frame(directed[k]);
    end

    base_pixels = pixels_sent;
    base_frames = frames_sent;
    squeezed = 1'b0;
    while (pixels_sent - base_pixels < RANDOM_PIXELS || frames_sent - base_frames < MIN_FRAMES)
    begin
      // Once: tiny back-to-back frames while the result side holds off for a long time.
      if (!squeezed && pixels_sent - base_pixels >= RANDOM_PIXELS / 2) begin
        apply_settings(1, 1, 1, 1);
        feed_tight = 1'b1;
        long_hold_req = 1'b1;
        repeat (40)
          send_frame(mk_case(0, 0, 0, 0, 0, $urandom_range(1, 3), FILL_NOISE, 0, 0, 0, 0, 0,
                             0, 0, 0, 0, 0));
        feed_tight = 1'b0;
        squeezed = 1'b1;
      end
      run_random_phase();
    end

    // Drain and let the pipeline settle.
    pixel_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("Sent %0d pixels in %0d frames under %0d register settings.",
             pixels_sent, frames_sent, settings_used);
    $display("Checked %0d results, %0d of them with a window found.",
             results_checked, frames_found);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still owed", owed_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
src/bws_pkg.sv
src/bws_line_store.sv
src/bws_column_sums.sv
src/bws_grid_check.sv
src/bws_window_eval.sv
src/brightest_window_search.sv
src/bws_checker.sv
tb/sv/brightest_window_search_tb.sv
